>>> src/dhb_pkg.sv
// ----------------------------------------------------------------------------
// dhb_pkg
// Shared types and constants of the dual H-bridge PWM brake controller.
// ----------------------------------------------------------------------------
package dhb_pkg;

   localparam int unsigned DUTY_W = 16;

   typedef enum logic [2:0] {
      OP_SET       = 3'd0,
      OP_BRAKE     = 3'd1,
      OP_TICK      = 3'd2,
      OP_STOP_ALL  = 3'd3,
      OP_BRAKE_ALL = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_DUTY_LOW   = 2'd0,
      CSR_DUTY_MID   = 2'd1,
      CSR_DUTY_FULL  = 2'd2,
      CSR_BRAKE_TIME = 2'd3
   } csr_index_type;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BWD  = 2'd2;

   localparam logic [DUTY_W-1:0] DUTY_LOW_RST   = 16'd960;
   localparam logic [DUTY_W-1:0] DUTY_MID_RST   = 16'd1680;
   localparam logic [DUTY_W-1:0] DUTY_FULL_RST  = 16'd2399;
   localparam logic [DUTY_W-1:0] BRAKE_TIME_RST = 16'd150;

   typedef struct packed {
      logic              drive;
      logic [1:0]        dir;
      logic [DUTY_W-1:0] duty;
      logic              brake;
      logic              tick;
   } motor_cmd_type;

endpackage

>>> src/dhb_motor.sv
// ----------------------------------------------------------------------------
// dhb_motor
// State of one H-bridge: compare values, brake pulse flag and brake timer.
// ----------------------------------------------------------------------------
module dhb_motor (
   input  logic                          clock,
   input  logic                          reset,
   input  dhb_pkg::motor_cmd_type        cmd,
   input  logic [dhb_pkg::DUTY_W-1:0]    duty_full,
   input  logic [dhb_pkg::DUTY_W-1:0]    brake_time,
   output logic [dhb_pkg::DUTY_W-1:0]    a_compare,
   output logic [dhb_pkg::DUTY_W-1:0]    b_compare,
   output logic                          braking
);
   import dhb_pkg::*;

   logic [DUTY_W-1:0] a_ff, a_in;
   logic [DUTY_W-1:0] b_ff, b_in;
   logic [DUTY_W-1:0] elapsed_ff, elapsed_in;
   logic              active_ff, active_in;
   logic              spent_ff, spent_in;

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      elapsed_in = elapsed_ff;
      active_in  = active_ff;
      spent_in   = spent_ff;
      if (cmd.drive) begin
         active_in  = 1'b0;
         elapsed_in = '0;
         case (cmd.dir)
            DIR_FWD: begin
               a_in     = cmd.duty;
               b_in     = '0;
               spent_in = 1'b0;
            end
            DIR_BWD: begin
               a_in     = '0;
               b_in     = cmd.duty;
               spent_in = 1'b0;
            end
            default: begin
               a_in     = '0;
               b_in     = '0;
               spent_in = 1'b1;
            end
         endcase
      end else if (cmd.brake) begin
         if (!active_ff && !spent_ff) begin
            a_in       = duty_full;
            b_in       = duty_full;
            active_in  = 1'b1;
            elapsed_in = '0;
         end
      end else if (cmd.tick && active_ff) begin
         if (elapsed_ff < brake_time) begin
            elapsed_in = elapsed_ff + 16'd1;
         end
         if (elapsed_in >= brake_time) begin
            a_in      = '0;
            b_in      = '0;
            active_in = 1'b0;
            spent_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff       <= '0;
         b_ff       <= '0;
         elapsed_ff <= '0;
         active_ff  <= 1'b0;
         spent_ff   <= 1'b1;
      end else begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         elapsed_ff <= elapsed_in;
         active_ff  <= active_in;
         spent_ff   <= spent_in;
      end
   end

   assign a_compare = a_ff;
   assign b_compare = b_ff;
   assign braking   = active_ff;

endmodule

>>> src/dual_hbridge_pwm_brake_control.sv
// ----------------------------------------------------------------------------
// dual_hbridge_pwm_brake_control
// Two H-bridge motors driven through four PWM compare values, with brake pulse.
// ----------------------------------------------------------------------------
// The result of an accepted transaction is registered and shown in the next cycle.
// Throughput: one transaction per cycle; the motor state registers are the
// result register, so input stalls only while a result is held by rsp_stall.
// Reset: both motors coast with brake marked done, compare values zero,
// configuration registers at their default values.
module dual_hbridge_pwm_brake_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_opcode,
   input  logic                          req_motor_id,
   input  logic [1:0]                    req_direction,
   input  logic [1:0]                    req_speed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dhb_pkg::DUTY_W-1:0]    rsp_left_a_compare,
   output logic [dhb_pkg::DUTY_W-1:0]    rsp_left_b_compare,
   output logic [dhb_pkg::DUTY_W-1:0]    rsp_right_a_compare,
   output logic [dhb_pkg::DUTY_W-1:0]    rsp_right_b_compare,
   output logic                          rsp_left_braking,
   output logic                          rsp_right_braking,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [dhb_pkg::DUTY_W-1:0]    csr_data
);
   import dhb_pkg::*;

   logic [DUTY_W-1:0] duty_low_ff, duty_mid_ff, duty_full_ff, brake_time_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic [DUTY_W-1:0] level_duty;
   motor_cmd_type     left_cmd, right_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_low_ff   <= DUTY_LOW_RST;
         duty_mid_ff   <= DUTY_MID_RST;
         duty_full_ff  <= DUTY_FULL_RST;
         brake_time_ff <= BRAKE_TIME_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DUTY_LOW:   duty_low_ff   <= csr_data;
            CSR_DUTY_MID:   duty_mid_ff   <= csr_data;
            CSR_DUTY_FULL:  duty_full_ff  <= csr_data;
            CSR_BRAKE_TIME: brake_time_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (req_speed)
         2'd2:    level_duty = duty_mid_ff;
         2'd3:    level_duty = duty_full_ff;
         default: level_duty = duty_low_ff;
      endcase
   end

   always_comb begin
      left_cmd       = '0;
      right_cmd      = '0;
      left_cmd.dir   = req_direction;
      right_cmd.dir  = req_direction;
      left_cmd.duty  = level_duty;
      right_cmd.duty = level_duty;
      if (accept) begin
         case (opcode_type'(req_opcode))
            OP_SET: begin
               left_cmd.drive  = !req_motor_id;
               right_cmd.drive = req_motor_id;
            end
            OP_BRAKE: begin
               left_cmd.brake  = !req_motor_id;
               right_cmd.brake = req_motor_id;
            end
            OP_TICK: begin
               left_cmd.tick  = 1'b1;
               right_cmd.tick = 1'b1;
            end
            OP_STOP_ALL: begin
               left_cmd.drive  = 1'b1;
               right_cmd.drive = 1'b1;
               left_cmd.dir    = DIR_STOP;
               right_cmd.dir   = DIR_STOP;
            end
            OP_BRAKE_ALL: begin
               left_cmd.brake  = 1'b1;
               right_cmd.brake = 1'b1;
            end
            default: ;
         endcase
      end
   end

   dhb_motor u_left (
      .clock      (clock),
      .reset      (reset),
      .cmd        (left_cmd),
      .duty_full  (duty_full_ff),
      .brake_time (brake_time_ff),
      .a_compare  (rsp_left_a_compare),
      .b_compare  (rsp_left_b_compare),
      .braking    (rsp_left_braking)
   );

   dhb_motor u_right (
      .clock      (clock),
      .reset      (reset),
      .cmd        (right_cmd),
      .duty_full  (duty_full_ff),
      .brake_time (brake_time_ff),
      .a_compare  (rsp_right_a_compare),
      .b_compare  (rsp_right_b_compare),
      .braking    (rsp_right_braking)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/dhb_checker.sv
// ----------------------------------------------------------------------------
// dhb_checker
// Port-level assertions for the dual H-bridge PWM brake controller.
// ----------------------------------------------------------------------------
module dhb_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [dhb_pkg::DUTY_W-1:0]    rsp_left_a_compare,
   input  logic [dhb_pkg::DUTY_W-1:0]    rsp_left_b_compare,
   input  logic [dhb_pkg::DUTY_W-1:0]    rsp_right_a_compare,
   input  logic [dhb_pkg::DUTY_W-1:0]    rsp_right_b_compare,
   input  logic                          rsp_left_braking,
   input  logic                          rsp_right_braking
);

   a_held_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_a_compare)
         && $stable(rsp_right_b_compare) && $stable(rsp_left_braking))
      else $error("stalled transaction changed");

   a_accept_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction gave no result");

   a_no_idle_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_brake_equal : assert property (@(posedge clock) disable iff (reset)
      (rsp_left_braking |-> rsp_left_a_compare == rsp_left_b_compare)
      and (rsp_right_braking |-> rsp_right_a_compare == rsp_right_b_compare))
      else $error("braking motor with unequal compares");

endmodule

bind dual_hbridge_pwm_brake_control dhb_checker u_dhb_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_left_a_compare  (rsp_left_a_compare),
   .rsp_left_b_compare  (rsp_left_b_compare),
   .rsp_right_a_compare (rsp_right_a_compare),
   .rsp_right_b_compare (rsp_right_b_compare),
   .rsp_left_braking    (rsp_left_braking),
   .rsp_right_braking   (rsp_right_braking)
);

>>> tb/dhb_brake_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhb_brake_checker
// Watches the command, status and register channels of the dual H-bridge
// controller, keeps its own copy of the motor and brake state, predicts the
// status returned for every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module dhb_brake_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [2:0]                 req_opcode,
   input  logic                       req_motor_id,
   input  logic [1:0]                 req_direction,
   input  logic [1:0]                 req_speed,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [dhb_pkg::DUTY_W-1:0] rsp_left_a_compare,
   input  logic [dhb_pkg::DUTY_W-1:0] rsp_left_b_compare,
   input  logic [dhb_pkg::DUTY_W-1:0] rsp_right_a_compare,
   input  logic [dhb_pkg::DUTY_W-1:0] rsp_right_b_compare,
   input  logic                       rsp_left_braking,
   input  logic                       rsp_right_braking,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [dhb_pkg::DUTY_W-1:0] csr_data,
   output int unsigned                error_count,
   output logic                       drained
);
   import dhb_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] left_a;
      logic [DUTY_W-1:0] left_b;
      logic [DUTY_W-1:0] right_a;
      logic [DUTY_W-1:0] right_b;
      logic              left_brk;
      logic              right_brk;
   } bridge_status_type;

   logic [DUTY_W-1:0] duty_lo, duty_md, duty_fl, brake_len;
   logic [1:0]        motor_dir   [2];
   logic              braking     [2];
   logic              brake_spent [2];
   logic [DUTY_W-1:0] brake_count [2];
   logic [DUTY_W-1:0] cmp         [4];

   bridge_status_type pending_status_q [$];

   initial begin
      error_count = 0;
      drained     = 1'b1;
   end

   function automatic logic [DUTY_W-1:0] level_duty(logic [1:0] spd);
      case (spd)
         2'd2:    return duty_md;
         2'd3:    return duty_fl;
         default: return duty_lo;
      endcase
   endfunction

   function automatic void apply_drive(int m, logic [1:0] dir, logic [1:0] spd);
      logic [DUTY_W-1:0] d;
      logic [1:0]        eff;
      d   = level_duty(spd);
      eff = dir;
      case (dir)
         DIR_FWD: begin
            cmp[2*m]   = d;
            cmp[2*m+1] = '0;
         end
         DIR_BWD: begin
            cmp[2*m]   = '0;
            cmp[2*m+1] = d;
         end
         default: begin
            cmp[2*m]   = '0;
            cmp[2*m+1] = '0;
            eff        = DIR_STOP;
         end
      endcase
      motor_dir[m]   = eff;
      braking[m]     = 1'b0;
      brake_count[m] = '0;
      brake_spent[m] = (eff == DIR_STOP);
   endfunction

   function automatic void apply_brake(int m);
      if (braking[m] || brake_spent[m]) return;
      cmp[2*m]       = duty_fl;
      cmp[2*m+1]     = duty_fl;
      motor_dir[m]   = DIR_STOP;
      braking[m]     = 1'b1;
      brake_count[m] = '0;
   endfunction

   function automatic void apply_ms_tick();
      for (int m = 0; m < 2; m++) begin
         if (braking[m]) begin
            if (brake_count[m] < brake_len) brake_count[m] = brake_count[m] + 16'd1;
            if (brake_count[m] >= brake_len) begin
               cmp[2*m]       = '0;
               cmp[2*m+1]     = '0;
               braking[m]     = 1'b0;
               brake_spent[m] = 1'b1;
            end
         end
      end
   endfunction

   function automatic bridge_status_type predict_bridge_status(logic [2:0] op, logic m,
                                                               logic [1:0] dir,
                                                               logic [1:0] spd);
      bridge_status_type s;
      case (op)
         OP_SET:       apply_drive(int'(m), dir, spd);
         OP_BRAKE:     apply_brake(int'(m));
         OP_TICK:      apply_ms_tick();
         OP_STOP_ALL: begin
            apply_drive(0, DIR_STOP, 2'd3);
            apply_drive(1, DIR_STOP, 2'd3);
         end
         OP_BRAKE_ALL: begin
            apply_brake(0);
            apply_brake(1);
         end
         default: ;
      endcase
      s.left_a    = cmp[0];
      s.left_b    = cmp[1];
      s.right_a   = cmp[2];
      s.right_b   = cmp[3];
      s.left_brk  = braking[0];
      s.right_brk = braking[1];
      return s;
   endfunction

   task automatic check_field(string field, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      bridge_status_type want;
      if (reset) begin
         duty_lo = DUTY_LOW_RST;
         duty_md = DUTY_MID_RST;
         duty_fl = DUTY_FULL_RST;
         brake_len = BRAKE_TIME_RST;
         for (int m = 0; m < 2; m++) begin
            motor_dir[m]   = DIR_STOP;
            braking[m]     = 1'b0;
            brake_spent[m] = 1'b1;
            brake_count[m] = '0;
         end
         for (int i = 0; i < 4; i++) cmp[i] = '0;
         pending_status_q.delete();
         drained <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DUTY_LOW:   duty_lo   = csr_data;
               CSR_DUTY_MID:   duty_md   = csr_data;
               CSR_DUTY_FULL:  duty_fl   = csr_data;
               CSR_BRAKE_TIME: brake_len = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_status_q.size() == 0) begin
               $error("status transaction with no command outstanding");
               error_count++;
            end else begin
               want = pending_status_q.pop_front();
               check_field("left_a_compare",  want.left_a,    rsp_left_a_compare);
               check_field("left_b_compare",  want.left_b,    rsp_left_b_compare);
               check_field("right_a_compare", want.right_a,   rsp_right_a_compare);
               check_field("right_b_compare", want.right_b,   rsp_right_b_compare);
               check_field("left_braking",    DUTY_W'(want.left_brk),
                           DUTY_W'(rsp_left_braking));
               check_field("right_braking",   DUTY_W'(want.right_brk),
                           DUTY_W'(rsp_right_braking));
            end
         end
         if (req_valid && !req_stall)
            pending_status_q.push_back(predict_bridge_status(req_opcode, req_motor_id,
                                                             req_direction, req_speed));
         drained <= (pending_status_q.size() == 0);
      end
   end

endmodule

>>> tb/tb_dual_hbridge_pwm_brake_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_hbridge_pwm_brake_control
// Drives directed and random motor commands, ticks and register settings into
// the dual H-bridge controller with random gaps and status backpressure; the
// checker predicts and compares every status transaction.
// ----------------------------------------------------------------------------
module tb_dual_hbridge_pwm_brake_control;
   import dhb_pkg::*;

   localparam int         ITEMS_PER_PHASE = 325;
   localparam int         RANDOM_PHASES   = 6;
   localparam int         IDLE_LIMIT      = 2000;
   localparam int         TAIL_CYCLES     = 4;
   localparam logic [2:0] OP_RSVD_LO      = 3'd5;
   localparam logic [2:0] OP_RSVD_HI      = 3'd7;
   localparam logic [1:0] DIR_ALT_STOP    = 2'd3;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [2:0]        req_opcode    = OP_TICK;
   logic              req_motor_id  = 1'b0;
   logic [1:0]        req_direction = DIR_STOP;
   logic [1:0]        req_speed     = 2'd0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [DUTY_W-1:0] rsp_left_a_compare, rsp_left_b_compare;
   logic [DUTY_W-1:0] rsp_right_a_compare, rsp_right_b_compare;
   logic              rsp_left_braking, rsp_right_braking;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index     = CSR_DUTY_LOW;
   logic [DUTY_W-1:0] csr_data      = '0;

   logic        no_idle = 1'b0;
   int unsigned error_count;
   logic        drained;
   int          stall_left  = 0;
   int          idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dual_hbridge_pwm_brake_control dut (.*);

   dhb_brake_checker checker_i (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(input logic [2:0] op, input logic m, input logic [1:0] dir,
                           input logic [1:0] spd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_motor_id  <= m;
      req_direction <= dir;
      req_speed     <= spd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
      do @(posedge clock); while (!drained);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DUTY_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] md,
                               input logic [DUTY_W-1:0] fl, input logic [DUTY_W-1:0] bt);
      write_reg(CSR_DUTY_LOW, lo);
      write_reg(CSR_DUTY_MID, md);
      write_reg(CSR_DUTY_FULL, fl);
      write_reg(CSR_BRAKE_TIME, bt);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int         phase;
      int         done_items;
      int         r;
      logic [2:0] op;
      logic [1:0] dir;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: brake before any drive, clamped speed, repeated brake,
      // stop alias, reserved opcodes, stop all then brake all with nothing to brake
      send_cmd(OP_BRAKE, 1'b0, DIR_STOP, 2'd0);
      send_cmd(OP_TICK, 1'b1, DIR_BWD, 2'd3);
      send_cmd(OP_SET, 1'b0, DIR_FWD, 2'd0);
      send_cmd(OP_SET, 1'b1, DIR_BWD, 2'd3);
      send_cmd(OP_SET, 1'b0, DIR_BWD, 2'd2);
      send_cmd(OP_SET, 1'b0, DIR_FWD, 2'd1);
      send_cmd(OP_BRAKE, 1'b0, DIR_FWD, 2'd1);
      send_cmd(OP_BRAKE, 1'b0, DIR_BWD, 2'd2);
      send_cmd(OP_TICK, 1'b0, DIR_STOP, 2'd0);
      send_cmd(OP_SET, 1'b1, DIR_ALT_STOP, 2'd2);
      send_cmd(OP_BRAKE, 1'b1, DIR_STOP, 2'd0);
      send_cmd(OP_RSVD_LO, 1'b1, DIR_ALT_STOP, 2'd3);
      send_cmd(OP_RSVD_LO + 3'd1, 1'b0, DIR_FWD, 2'd1);
      send_cmd(OP_RSVD_HI, 1'b1, DIR_BWD, 2'd2);
      send_cmd(OP_STOP_ALL, 1'b0, DIR_FWD, 2'd3);
      send_cmd(OP_BRAKE_ALL, 1'b1, DIR_STOP, 2'd0);
      finish_burst();

      // zero brake time: pulse ends at the first tick
      program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_cmd(OP_SET, 1'b0, DIR_FWD, 2'd3);
      send_cmd(OP_SET, 1'b1, DIR_BWD, 2'd2);
      send_cmd(OP_BRAKE_ALL, 1'b0, DIR_STOP, 2'd0);
      send_cmd(OP_TICK, 1'b0, DIR_STOP, 2'd0);
      send_cmd(OP_TICK, 1'b1, DIR_STOP, 2'd0);
      send_cmd(OP_BRAKE_ALL, 1'b1, DIR_FWD, 2'd1);
      finish_burst();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle <= (phase == 2);
         case (phase)
            0: program_regs(16'h0000, 16'($urandom), 16'hFFFF, 16'd1);
            1: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'd2);
            2: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(1, 6)));
            3: program_regs(16'hFFFF, 16'h0000, 16'($urandom), 16'hFFFF);
            4: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'd3);
            default: program_regs(DUTY_LOW_RST, DUTY_MID_RST, DUTY_FULL_RST,
                                  16'($urandom_range(1, 4)));
         endcase
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 30)      op = OP_SET;
            else if (r < 45) op = OP_BRAKE;
            else if (r < 75) op = OP_TICK;
            else if (r < 80) op = OP_STOP_ALL;
            else if (r < 92) op = OP_BRAKE_ALL;
            else             op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            r = $urandom_range(0, 9);
            if (r < 4)       dir = DIR_FWD;
            else if (r < 8)  dir = DIR_BWD;
            else if (r == 8) dir = DIR_STOP;
            else             dir = DIR_ALT_STOP;
            send_cmd(op, 1'($urandom), dir, 2'($urandom));
            done_items++;
         end
         finish_burst();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
